@@ rtl/cbad_pkg.sv @@
package cbad_pkg;

   typedef struct packed {
      logic        action;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } req_type;

   typedef struct packed {
      logic [2:0]  region;
      logic [14:0] mapped_addr;
      logic [7:0]  rdata;
      logic [1:0]  fault;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_RAM,
      KIND_AUDIO,
      KIND_OTHER
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        write;
      logic [7:0]  wdata;
      logic [2:0]  region;
      logic [14:0] mapped_addr;
      logic [1:0]  fault;
   } cmd_type;

   localparam logic [2:0] REGION_RAM   = 3'd0;
   localparam logic [2:0] REGION_PIC   = 3'd1;
   localparam logic [2:0] REGION_AUDIO = 3'd2;
   localparam logic [2:0] REGION_ROM   = 3'd3;
   localparam logic [2:0] REGION_NONE  = 3'd4;

   localparam logic [1:0] FAULT_NONE      = 2'd0;
   localparam logic [1:0] FAULT_ROM_WRITE = 2'd1;
   localparam logic [1:0] FAULT_UNMAPPED  = 2'd2;

   localparam logic ACTION_WRITE = 1'b1;

   localparam int AUDIO_DEPTH     = 24;
   localparam int AUDIO_IDX_BITS  = 5;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = 1;

   localparam logic [15:0] RAM_LAST   = 16'h1FFF;
   localparam logic [15:0] PIC_LAST   = 16'h3FFF;
   localparam logic [15:0] AUDIO_BASE = 16'h4000;
   localparam logic [15:0] AUDIO_LAST = 16'h4013;
   localparam logic [15:0] AUDIO_STAT = 16'h4015;
   localparam logic [15:0] AUDIO_FRAME = 16'h4017;
   localparam logic [15:0] ROM_BASE   = 16'h8000;

   localparam logic CSR_IDX_PRG_IS_16K = 1'b0;

endpackage

@@ rtl/console_bus_address_decoder.sv @@
// channel   ports                                   role
// req       push, full, req_item                    bus access in (action, addr, wdata)
// rsp       empty, pop, rsp_item                    decode result out (region, offset, byte, fault)
// csr       psel, penable, pwrite, paddr, pwdata,   prg_is_16k at byte address 0
//           prdata, pready
//
// sustained rate is one item per cycle while rsp is not stalled and the ram is not being cleared; an item
// reaches rsp through the front queue, then the back part's stage and work ram read registers, then the rsp queue
// after reset the work ram is zeroed one entry a cycle, 2**WRAM_ADDR_BITS entries
// (2048 by default): full stays high until the clear is done, csr writes are taken meanwhile
// a stalled rsp side backs up through two short queues before full rises
module console_bus_address_decoder #(
   parameter int WRAM_ADDR_BITS = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cbad_pkg::req_type req_item,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output cbad_pkg::rsp_type rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic              prg_is_16k_ff, prg_is_16k_in;
   logic              csr_write;
   logic              mid_push, mid_full, mid_empty, mid_pop;
   logic              clearing;
   logic              rsp_push, rsp_full;
   cbad_pkg::cmd_type cmd_in, cmd_out;
   cbad_pkg::rsp_type rsp_in;
   logic [$bits(cbad_pkg::cmd_type)-1:0] mid_dout;
   logic [$bits(cbad_pkg::rsp_type)-1:0] rsp_dout;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == cbad_pkg::CSR_IDX_PRG_IS_16K) ?
                      {31'd0, prg_is_16k_ff} : 32'd0;

   always_comb begin
      prg_is_16k_in = prg_is_16k_ff;
      if (csr_write && paddr[2] == cbad_pkg::CSR_IDX_PRG_IS_16K) begin
         prg_is_16k_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_is_16k_ff <= 1'b0;
      end else begin
         prg_is_16k_ff <= prg_is_16k_in;
      end
   end

   cbad_front #(
      .WRAM_ADDR_BITS(WRAM_ADDR_BITS)
   ) u_front (
      .push       (push),
      .req_item   (req_item),
      .prg_is_16k (prg_is_16k_ff),
      .queue_full (mid_full),
      .clearing   (clearing),
      .full       (full),
      .queue_push (mid_push),
      .cmd        (cmd_in)
   );

   cbad_fifo #(
      .WIDTH($bits(cbad_pkg::cmd_type))
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .din   (cmd_in),
      .full  (mid_full),
      .pop   (mid_pop),
      .dout  (mid_dout),
      .empty (mid_empty)
   );

   assign cmd_out = cbad_pkg::cmd_type'(mid_dout);

   cbad_back #(
      .WRAM_ADDR_BITS(WRAM_ADDR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!mid_empty),
      .cmd       (cmd_out),
      .cmd_pop   (mid_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in),
      .clearing  (clearing)
   );

   cbad_fifo #(
      .WIDTH($bits(cbad_pkg::rsp_type))
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_in),
      .full  (rsp_full),
      .pop   (pop),
      .dout  (rsp_dout),
      .empty (empty)
   );

   assign rsp_item = cbad_pkg::rsp_type'(rsp_dout);

`ifndef ASSERT_OFF
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_no_clear_restart: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$rose(clearing))
      else $error("ram clear restarted without reset");

   a_unmapped_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.region == cbad_pkg::REGION_NONE) |->
      (rsp_item.mapped_addr == 15'd0 && rsp_item.rdata == 8'd0
       && rsp_item.fault == cbad_pkg::FAULT_UNMAPPED))
      else $error("unmapped item with offset, data or wrong fault");

   a_fault_only_rom: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.fault == cbad_pkg::FAULT_ROM_WRITE) |->
      (rsp_item.region == cbad_pkg::REGION_ROM && rsp_item.rdata == 8'd0))
      else $error("rom write fault outside rom region");
`endif

endmodule

@@ rtl/cbad_fifo.sv @@
module cbad_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PB = cbad_pkg::QUEUE_PTR_BITS;

   logic [WIDTH-1:0] mem_ff [cbad_pkg::QUEUE_DEPTH];
   logic [PB-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PB:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PB+1)'(cbad_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign dout    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + PB'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + PB'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PB+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PB+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

@@ rtl/cbad_front.sv @@
module cbad_front #(
   parameter int WRAM_ADDR_BITS = 11
) (
   input  logic              push,
   input  cbad_pkg::req_type req_item,
   input  logic              prg_is_16k,
   input  logic              queue_full,
   input  logic              clearing,
   output logic              full,
   output logic              queue_push,
   output cbad_pkg::cmd_type cmd
);

   logic [15:0] a;
   logic        wr;
   logic        is_audio;

   assign a    = req_item.addr;
   assign wr   = (req_item.action == cbad_pkg::ACTION_WRITE);
   assign full = queue_full || clearing;
   assign queue_push = push && !full;

   assign is_audio = (a >= cbad_pkg::AUDIO_BASE && a <= cbad_pkg::AUDIO_LAST)
                     || a == cbad_pkg::AUDIO_STAT || a == cbad_pkg::AUDIO_FRAME;

   always_comb begin
      cmd             = '0;
      cmd.kind        = cbad_pkg::KIND_OTHER;
      cmd.write       = wr;
      cmd.wdata       = req_item.wdata;
      cmd.region      = cbad_pkg::REGION_NONE;
      cmd.mapped_addr = '0;
      cmd.fault       = cbad_pkg::FAULT_UNMAPPED;
      if (a <= cbad_pkg::RAM_LAST) begin
         cmd.kind        = cbad_pkg::KIND_RAM;
         cmd.region      = cbad_pkg::REGION_RAM;
         cmd.mapped_addr = 15'(a[WRAM_ADDR_BITS-1:0]);
         cmd.fault       = cbad_pkg::FAULT_NONE;
      end else if (a <= cbad_pkg::PIC_LAST) begin
         if (!wr) begin
            cmd.region      = cbad_pkg::REGION_PIC;
            cmd.mapped_addr = 15'(a[2:0]);
            cmd.fault       = cbad_pkg::FAULT_NONE;
         end
      end else if (is_audio) begin
         cmd.kind        = cbad_pkg::KIND_AUDIO;
         cmd.region      = cbad_pkg::REGION_AUDIO;
         cmd.mapped_addr = 15'(a[cbad_pkg::AUDIO_IDX_BITS-1:0]);
         cmd.fault       = cbad_pkg::FAULT_NONE;
      end else if (a >= cbad_pkg::ROM_BASE) begin
         cmd.region      = cbad_pkg::REGION_ROM;
         cmd.mapped_addr = {a[14] && !prg_is_16k, a[13:0]};
         cmd.fault       = wr ? cbad_pkg::FAULT_ROM_WRITE : cbad_pkg::FAULT_NONE;
      end
   end

endmodule

@@ rtl/cbad_back.sv @@
module cbad_back #(
   parameter int WRAM_ADDR_BITS = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cbad_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output cbad_pkg::rsp_type rsp,
   output logic              clearing
);

   localparam int RAM_DEPTH = 1 << WRAM_ADDR_BITS;
   localparam int AB = cbad_pkg::AUDIO_IDX_BITS;

   logic [7:0]                ram [RAM_DEPTH];
   logic [7:0]                audio_ff [cbad_pkg::AUDIO_DEPTH];
   logic [7:0]                ram_rd_ff;
   logic [7:0]                audio_rd_ff;
   logic                      clr_busy_ff, clr_busy_in;
   logic [WRAM_ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                      s_valid_ff, s_valid_in;
   cbad_pkg::cmd_type         s_cmd_ff;

   logic                      s_adv, take;
   logic                      ram_we, ram_re, aud_we, aud_re;
   logic [WRAM_ADDR_BITS-1:0] ram_idx, ram_wa;
   logic [7:0]                ram_wd;
   logic [AB-1:0]             aud_idx;

   assign clearing = clr_busy_ff;
   assign s_adv    = s_valid_ff && !rsp_full;
   assign take     = cmd_valid && !clr_busy_ff && (!s_valid_ff || s_adv);
   assign cmd_pop  = take;
   assign rsp_push = s_adv;

   assign ram_idx = cmd.mapped_addr[WRAM_ADDR_BITS-1:0];
   assign aud_idx = cmd.mapped_addr[AB-1:0];
   assign ram_re  = take && cmd.kind == cbad_pkg::KIND_RAM && !cmd.write;
   assign ram_we  = clr_busy_ff || (take && cmd.kind == cbad_pkg::KIND_RAM && cmd.write);
   assign ram_wa  = clr_busy_ff ? clr_addr_ff : ram_idx;
   assign ram_wd  = clr_busy_ff ? 8'd0 : cmd.wdata;
   assign aud_re  = take && cmd.kind == cbad_pkg::KIND_AUDIO && !cmd.write;
   assign aud_we  = take && cmd.kind == cbad_pkg::KIND_AUDIO && cmd.write;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + WRAM_ADDR_BITS'(1);
         if (clr_addr_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
      s_valid_in = s_valid_ff;
      if (take) begin
         s_valid_in = 1'b1;
      end else if (s_adv) begin
         s_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp.region      = s_cmd_ff.region;
      rsp.mapped_addr = s_cmd_ff.mapped_addr;
      rsp.fault       = s_cmd_ff.fault;
      rsp.rdata       = 8'd0;
      if (!s_cmd_ff.write) begin
         case (s_cmd_ff.kind)
            cbad_pkg::KIND_RAM:   rsp.rdata = ram_rd_ff;
            cbad_pkg::KIND_AUDIO: rsp.rdata = audio_rd_ff;
            default:              rsp.rdata = 8'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s_valid_ff  <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         s_valid_ff  <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s_cmd_ff <= cmd;
      end
   end

   // work ram, one write and one registered read port
   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram[ram_wa] <= ram_wd;
      end
      if (ram_re) begin
         ram_rd_ff <= ram[ram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbad_pkg::AUDIO_DEPTH; i++) begin
            audio_ff[i] <= 8'd0;
         end
      end else if (aud_we) begin
         audio_ff[aud_idx] <= cmd.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (aud_re) begin
         audio_rd_ff <= audio_ff[aud_idx];
      end
   end

endmodule
